[hdl/bma_pkg.sv]
// ----------------------------------------------------------------------------
// bma_pkg
// shared types, sizes and glyph table for the block-mean ascii-art unit
// ----------------------------------------------------------------------------
`default_nettype none

package bma_pkg;

    localparam int MAX_IMAGE_WIDTH = 4096;
    localparam int MAX_CELL_WIDTH  = 32;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int ADDR_W          = $clog2(MAX_IMAGE_WIDTH);
    localparam int SUM_W           = 20;
    localparam int DIVISOR_W       = 12;
    localparam int DIV_STEPS       = SUM_W;
    localparam int STEP_W          = $clog2(DIV_STEPS);
    localparam int CFG_DATA_W      = 13;

    typedef enum logic [1:0] {
        CFG_CELL_WIDTH   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic [7:0] cell_mean;
        logic       row_end;
    } out_beat_t;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [SUM_W-1:0]     quotient;
        logic [DIVISOR_W-1:0] remainder;
    } div_rsp_t;

    localparam logic [6:0] CHAR_AT    = 7'h40;
    localparam logic [6:0] CHAR_HASH  = 7'h23;
    localparam logic [6:0] CHAR_STAR  = 7'h2A;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_DOT   = 7'h2E;
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    function automatic logic [6:0] glyph_for(input logic [7:0] m);
        logic [6:0] g;
        if (m < 8'd50) begin
            g = CHAR_AT;
        end else if (m < 8'd90) begin
            g = CHAR_HASH;
        end else if (m < 8'd120) begin
            g = CHAR_STAR;
        end else if (m < 8'd155) begin
            g = CHAR_PLUS;
        end else if (m < 8'd170) begin
            g = CHAR_DOT;
        end else begin
            g = CHAR_SPACE;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

[hdl/bma_sum_ram.sv]
// ----------------------------------------------------------------------------
// bma_sum_ram
// per-column cell sum store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bma_sum_ram (
    input  wire logic                       aclk,
    input  wire logic                       rd_en,
    input  wire logic [bma_pkg::ADDR_W-1:0] rd_addr,
    output logic      [bma_pkg::SUM_W-1:0]  rd_data,
    input  wire logic                       wr_en,
    input  wire logic [bma_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [bma_pkg::SUM_W-1:0]  wr_data
);

    logic [bma_pkg::SUM_W-1:0] mem [bma_pkg::MAX_IMAGE_WIDTH];
    logic [bma_pkg::SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/bma_div.sv]
// ----------------------------------------------------------------------------
// bma_div
// restoring divider, one quotient bit per cycle, shared by row limit and mean
// ----------------------------------------------------------------------------
`default_nettype none

module bma_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bma_pkg::div_req_t req,
    output bma_pkg::div_rsp_t      rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [bma_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [bma_pkg::SUM_W-1:0]           quot_reg, quot_next;
    logic [bma_pkg::DIVISOR_W-1:0]       rem_reg, rem_next;
    logic [bma_pkg::DIVISOR_W-1:0]       dvsr_reg, dvsr_next;
    logic [bma_pkg::DIVISOR_W:0]         shifted;
    logic [bma_pkg::DIVISOR_W:0]         diff;

    always_comb begin
        shifted   = {rem_reg, quot_reg[bma_pkg::SUM_W-1]};
        diff      = shifted - {1'b0, dvsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            quot_next = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvsr_reg}) begin
                rem_next  = diff[bma_pkg::DIVISOR_W-1:0];
                quot_next = {quot_reg[bma_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next  = shifted[bma_pkg::DIVISOR_W-1:0];
                quot_next = {quot_reg[bma_pkg::SUM_W-2:0], 1'b0};
            end
            if (step_reg == bma_pkg::STEP_W'(bma_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[hdl/block_mean_ascii_art_unit.sv]
// ----------------------------------------------------------------------------
// block_mean_ascii_art_unit
// tiles a gray raster into cells, averages each fitting cell and maps it to a glyph
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_valid/s_ready     in_beat_t  {pixel, frame_start}
// m_*       out  m_valid/m_ready     out_beat_t {char_code, cell_mean, row_end}
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a pixel beat: accept and sum-store read in idle, then write back in the read state
// a beat that closes a cell also waits on the 20-step shared divider
// after reset and after any config write the divider forms the row limit,
// with s_ready low
// the result register holds a cell while the next pixels are taken; the unit
// waits for m_ready only when a new cell is ready and the old one is not taken
// ----------------------------------------------------------------------------
`default_nettype none

module block_mean_ascii_art_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bma_pkg::in_beat_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bma_pkg::out_beat_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [bma_pkg::CFG_DATA_W-1:0] cfg_data
);

    bma_pkg::state_t state_reg, state_next;

    logic [5:0]  cell_width_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic        pending_reg, pending_next;
    logic [12:0] rows_limit_reg;

    logic [11:0] pixel_column_reg, pixel_column_next;
    logic [11:0] pixel_row_reg, pixel_row_next;
    logic [4:0]  column_in_cell_reg, column_in_cell_next;
    logic [6:0]  row_in_cell_reg, row_in_cell_next;
    logic [11:0] cell_index_reg, cell_index_next;

    logic [7:0]  px_reg;
    logic        first_reg, emit_reg, row_end_reg, in_range_reg;
    logic [11:0] addr_reg;
    logic [7:0]  mean_reg;

    logic        m_valid_reg;
    bma_pkg::out_beat_t m_data_reg;

    logic [5:0]  l_val;
    logic [7:0]  five_l;
    logic [6:0]  h_val;
    logic [12:0] area;
    logic [12:0] w_val;
    logic [12:0] h_img;

    logic [11:0] col_c, row_c, ci_c;
    logic [4:0]  cic_c;
    logic [6:0]  ric_c;
    logic [18:0] end_next_cell;
    logic [18:0] end_after_cell;
    logic        in_range_c, emit_c, row_end_c, first_c;

    logic        s_accept, cfg_accept, out_free;
    logic        div_start_init, div_start_mean, load_out, mem_wr;
    logic [19:0] sum_c;
    logic [19:0] rd_data;
    bma_pkg::div_req_t div_req;
    bma_pkg::div_rsp_t div_rsp;

    // clamped configuration
    always_comb begin
        if (cell_width_reg == 6'd0) begin
            l_val = 6'd1;
        end else if (cell_width_reg > 6'(bma_pkg::MAX_CELL_WIDTH)) begin
            l_val = 6'(bma_pkg::MAX_CELL_WIDTH);
        end else begin
            l_val = cell_width_reg;
        end
        if (image_width_reg == 13'd0) begin
            w_val = 13'd1;
        end else if (image_width_reg > 13'(bma_pkg::MAX_IMAGE_WIDTH)) begin
            w_val = 13'(bma_pkg::MAX_IMAGE_WIDTH);
        end else begin
            w_val = image_width_reg;
        end
        if (image_height_reg == 13'd0) begin
            h_img = 13'd1;
        end else if (image_height_reg > 13'(bma_pkg::HEIGHT_LIMIT)) begin
            h_img = 13'(bma_pkg::HEIGHT_LIMIT);
        end else begin
            h_img = image_height_reg;
        end
        five_l = {l_val, 2'b00} + {2'b00, l_val};
        h_val  = five_l[7:1];
        area   = {7'b0, l_val} * {6'b0, h_val};
    end

    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid;
    assign out_free   = !m_valid_reg || m_ready;

    // position of the incoming pixel, frame start applied
    always_comb begin
        col_c = s_data.frame_start ? 12'd0 : pixel_column_reg;
        row_c = s_data.frame_start ? 12'd0 : pixel_row_reg;
        ci_c  = s_data.frame_start ? 12'd0 : cell_index_reg;
        cic_c = s_data.frame_start ? 5'd0  : column_in_cell_reg;
        ric_c = s_data.frame_start ? 7'd0  : row_in_cell_reg;
        end_next_cell  = ({1'b0, ci_c} + 13'd1) * {13'b0, l_val};
        end_after_cell = ({1'b0, ci_c} + 13'd2) * {13'b0, l_val};
        in_range_c = end_next_cell <= {6'b0, w_val};
        row_end_c  = end_after_cell > {6'b0, w_val};
        first_c    = (cic_c == 5'd0) && (ric_c == 7'd0);
        emit_c     = in_range_c && ({1'b0, cic_c} == l_val - 6'd1)
                     && (ric_c == h_val - 7'd1) && ({1'b0, row_c} < rows_limit_reg);
    end

    // counter advance
    always_comb begin
        pixel_column_next   = pixel_column_reg;
        pixel_row_next      = pixel_row_reg;
        column_in_cell_next = column_in_cell_reg;
        row_in_cell_next    = row_in_cell_reg;
        cell_index_next     = cell_index_reg;
        if (s_accept) begin
            pixel_row_next   = row_c;
            row_in_cell_next = ric_c;
            if ({1'b0, col_c} >= w_val - 13'd1) begin
                pixel_column_next   = 12'd0;
                column_in_cell_next = 5'd0;
                cell_index_next     = 12'd0;
                if ({1'b0, row_c} >= h_img - 13'd1) begin
                    pixel_row_next   = 12'd0;
                    row_in_cell_next = 7'd0;
                end else begin
                    pixel_row_next = row_c + 12'd1;
                    if (ric_c >= h_val - 7'd1) begin
                        row_in_cell_next = 7'd0;
                    end else begin
                        row_in_cell_next = ric_c + 7'd1;
                    end
                end
            end else begin
                pixel_column_next = col_c + 12'd1;
                if ({1'b0, cic_c} >= l_val - 6'd1) begin
                    column_in_cell_next = 5'd0;
                    cell_index_next     = ci_c + 12'd1;
                end else begin
                    column_in_cell_next = cic_c + 5'd1;
                    cell_index_next     = ci_c;
                end
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bma_pkg::ST_INIT: begin
                state_next = bma_pkg::ST_INIT_WAIT;
            end
            bma_pkg::ST_INIT_WAIT: begin
                if (div_rsp.done) begin
                    state_next = bma_pkg::ST_IDLE;
                end
            end
            bma_pkg::ST_IDLE: begin
                if (pending_reg) begin
                    state_next = bma_pkg::ST_INIT;
                end else if (s_accept) begin
                    state_next = bma_pkg::ST_READ;
                end
            end
            bma_pkg::ST_READ: begin
                state_next = emit_reg ? bma_pkg::ST_DIV : bma_pkg::ST_IDLE;
            end
            bma_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = bma_pkg::ST_EMIT;
                end
            end
            bma_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = bma_pkg::ST_IDLE;
                end
            end
            default: state_next = bma_pkg::ST_INIT;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready        = 1'b0;
        div_start_init = 1'b0;
        div_start_mean = 1'b0;
        mem_wr         = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            bma_pkg::ST_INIT: begin
                div_start_init = 1'b1;
            end
            bma_pkg::ST_INIT_WAIT: begin
            end
            bma_pkg::ST_IDLE: begin
                s_ready = !pending_reg;
            end
            bma_pkg::ST_READ: begin
                mem_wr         = in_range_reg;
                div_start_mean = emit_reg;
            end
            bma_pkg::ST_DIV: begin
            end
            bma_pkg::ST_EMIT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    assign pending_next = cfg_accept ? 1'b1
                        : (state_reg == bma_pkg::ST_INIT) ? 1'b0 : pending_reg;

    assign sum_c = first_reg ? {12'b0, px_reg} : rd_data + {12'b0, px_reg};

    always_comb begin
        div_req.start = div_start_init || div_start_mean;
        if (div_start_init) begin
            div_req.dividend = {7'b0, h_img};
            div_req.divisor  = {5'b0, h_val};
        end else begin
            div_req.dividend = sum_c;
            div_req.divisor  = area[11:0];
        end
    end

    bma_sum_ram u_sum_ram (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (ci_c),
        .rd_data (rd_data),
        .wr_en   (mem_wr),
        .wr_addr (addr_reg),
        .wr_data (sum_c)
    );

    bma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= bma_pkg::ST_INIT;
            pending_reg        <= 1'b0;
            cell_width_reg     <= 6'd15;
            image_width_reg    <= 13'd640;
            image_height_reg   <= 13'd480;
            pixel_column_reg   <= '0;
            pixel_row_reg      <= '0;
            column_in_cell_reg <= '0;
            row_in_cell_reg    <= '0;
            cell_index_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            pending_reg        <= pending_next;
            pixel_column_reg   <= pixel_column_next;
            pixel_row_reg      <= pixel_row_next;
            column_in_cell_reg <= column_in_cell_next;
            row_in_cell_reg    <= row_in_cell_next;
            cell_index_reg     <= cell_index_next;
            if (cfg_accept) begin
                unique case (cfg_index)
                    bma_pkg::CFG_CELL_WIDTH:   cell_width_reg   <= cfg_data[5:0];
                    bma_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    bma_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg       <= s_data.pixel;
            first_reg    <= first_c;
            emit_reg     <= emit_c;
            row_end_reg  <= row_end_c;
            in_range_reg <= in_range_c;
            addr_reg     <= ci_c;
        end
        if (state_reg == bma_pkg::ST_INIT_WAIT && div_rsp.done) begin
            rows_limit_reg <= h_img - {1'b0, div_rsp.remainder};
        end
        if (state_reg == bma_pkg::ST_DIV && div_rsp.done) begin
            mean_reg <= (|div_rsp.quotient[19:8]) ? 8'd255 : div_rsp.quotient[7:0];
        end
        if (load_out) begin
            m_data_reg.char_code <= bma_pkg::glyph_for(mean_reg);
            m_data_reg.cell_mean <= mean_reg;
            m_data_reg.row_end   <= row_end_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[bench/cell_glyph_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_glyph_checker
// Watches the pixel, result and register channels of the ascii-art unit and
// keeps its own copy of the column sums, the position counters and the
// register values. Every accepted pixel beat that closes a fitting cell queues
// the expected glyph, mean and row-end flag. Every accepted result beat is
// compared field by field with the oldest queued cell.
// ----------------------------------------------------------------------------

module cell_glyph_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  bma_pkg::in_beat_t               s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  bma_pkg::out_beat_t              m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [bma_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                     mismatches,
    output int unsigned                     cells_due
);

    localparam int unsigned SUM_MASK   = (1 << bma_pkg::SUM_W) - 1;
    localparam int unsigned MAX_REPORT = 10;

    logic [5:0]                cell_w;
    logic [12:0]               img_w;
    logic [12:0]               img_h;
    logic [bma_pkg::SUM_W-1:0] col_sums [bma_pkg::MAX_IMAGE_WIDTH];
    logic [11:0]               x_pos;
    logic [11:0]               y_pos;
    logic [11:0]               cell_col;
    logic [4:0]                x_in_cell;
    logic [6:0]                y_in_cell;
    bma_pkg::out_beat_t        due_cells [$];
    bma_pkg::out_beat_t        oldest;
    int unsigned               fail_tally = 0;

    initial begin
        foreach (col_sums[i]) col_sums[i] = '0;
    end

    function automatic void predict_cell(input bma_pkg::in_beat_t beat);
        int unsigned lw, lh, fw, fh, ncols, nrows, sum, mean;
        bma_pkg::out_beat_t due;
        lw = (cell_w == 0) ? 1 :
             (cell_w > bma_pkg::MAX_CELL_WIDTH) ? bma_pkg::MAX_CELL_WIDTH : cell_w;
        lh = 5 * lw / 2;
        fw = (img_w == 0) ? 1 :
             (img_w > bma_pkg::MAX_IMAGE_WIDTH) ? bma_pkg::MAX_IMAGE_WIDTH : img_w;
        fh = (img_h == 0) ? 1 :
             (img_h > bma_pkg::HEIGHT_LIMIT) ? bma_pkg::HEIGHT_LIMIT : img_h;
        ncols = fw / lw;
        nrows = fh / lh;

        if (beat.frame_start) begin
            x_pos     = '0;
            y_pos     = '0;
            x_in_cell = '0;
            y_in_cell = '0;
            cell_col  = '0;
        end

        if (cell_col < ncols) begin
            if (x_in_cell == 0 && y_in_cell == 0) begin
                sum = beat.pixel;
            end else begin
                sum = (col_sums[cell_col] + beat.pixel) & SUM_MASK;
            end
            col_sums[cell_col] = sum;
            if (x_in_cell == lw - 1 && y_in_cell == lh - 1 && y_pos < nrows * lh) begin
                mean = sum / (lw * lh);
                if (mean > 255) mean = 255;
                due.cell_mean = 8'(mean);
                if (mean < 50) begin
                    due.char_code = bma_pkg::CHAR_AT;
                end else if (mean < 90) begin
                    due.char_code = bma_pkg::CHAR_HASH;
                end else if (mean < 120) begin
                    due.char_code = bma_pkg::CHAR_STAR;
                end else if (mean < 155) begin
                    due.char_code = bma_pkg::CHAR_PLUS;
                end else if (mean < 170) begin
                    due.char_code = bma_pkg::CHAR_DOT;
                end else begin
                    due.char_code = bma_pkg::CHAR_SPACE;
                end
                due.row_end = (cell_col == ncols - 1);
                due_cells.push_back(due);
            end
        end

        // raster position advance
        if (x_pos >= fw - 1) begin
            x_pos     = '0;
            x_in_cell = '0;
            cell_col  = '0;
            if (y_pos >= fh - 1) begin
                y_pos     = '0;
                y_in_cell = '0;
            end else begin
                y_pos++;
                if (y_in_cell >= lh - 1) begin
                    y_in_cell = '0;
                end else begin
                    y_in_cell++;
                end
            end
        end else begin
            x_pos++;
            if (x_in_cell >= lw - 1) begin
                x_in_cell = '0;
                cell_col++;
            end else begin
                x_in_cell++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cell_w    = 6'd15;
            img_w     = 13'd640;
            img_h     = 13'd480;
            x_pos     = '0;
            y_pos     = '0;
            x_in_cell = '0;
            y_in_cell = '0;
            cell_col  = '0;
            due_cells.delete();
        end else begin
            // result beat first: it never belongs to a pixel taken at this edge
            if (m_valid && m_ready) begin
                if (due_cells.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= MAX_REPORT) begin
                        $display("unexpected result beat: char %0d mean %0d row_end %0b",
                                 m_data.char_code, m_data.cell_mean, m_data.row_end);
                    end
                end else begin
                    oldest = due_cells.pop_front();
                    if (m_data.char_code !== oldest.char_code ||
                        m_data.cell_mean !== oldest.cell_mean ||
                        m_data.row_end   !== oldest.row_end) begin
                        fail_tally++;
                        if (fail_tally <= MAX_REPORT) begin
                            $display("result mismatch: expected char %0d mean %0d row_end %0b",
                                     oldest.char_code, oldest.cell_mean, oldest.row_end);
                            $display("                 got      char %0d mean %0d row_end %0b",
                                     m_data.char_code, m_data.cell_mean, m_data.row_end);
                        end
                    end
                end
            end
            // a pixel taken at the edge of a register write still sees the old value
            if (s_valid && s_ready) predict_cell(s_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bma_pkg::CFG_CELL_WIDTH:   cell_w = cfg_data[5:0];
                    bma_pkg::CFG_IMAGE_WIDTH:  img_w  = cfg_data;
                    bma_pkg::CFG_IMAGE_HEIGHT: img_h  = cfg_data;
                    default: ;
                endcase
            end
        end
        mismatches <= fail_tally;
        cells_due  <= due_cells.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives gray pixel beats, register writes and result back-pressure into the
// block-mean ascii-art unit. A short directed part walks the glyph thresholds
// and the clamping and saturation corners, then random frames under random
// settings follow. The checker beside the unit predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------

module tb;

    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned STALL_LIMIT   = 20000;
    localparam int unsigned RANDOM_BEATS  = 1600;
    localparam int unsigned MAX_PHASE     = 240;
    localparam logic [1:0]  SPARE_INDEX   = 2'd3;
    localparam logic [7:0]  GLYPH_EDGES [12] = '{8'd0, 8'd49, 8'd50, 8'd89, 8'd90, 8'd119,
                                                 8'd120, 8'd154, 8'd155, 8'd169, 8'd170,
                                                 8'd255};

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    bma_pkg::in_beat_t              s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    bma_pkg::out_beat_t             m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index = '0;
    logic [bma_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned mismatches;
    int unsigned cells_due;
    bit          calm        = 1'b0;
    int unsigned holds_asked = 0;
    int unsigned holds_done  = 0;
    int unsigned hold_left   = 0;
    int unsigned random_sent = 0;

    always #1 aclk = ~aclk;

    block_mean_ascii_art_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cell_glyph_checker cell_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .cells_due  (cells_due)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_asked;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [5:0] cw, input logic [12:0] iw, input logic [12:0] ih);
        write_reg(bma_pkg::CFG_CELL_WIDTH, 13'(cw));
        write_reg(bma_pkg::CFG_IMAGE_WIDTH, iw);
        write_reg(bma_pkg::CFG_IMAGE_HEIGHT, ih);
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic fs);
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{pixel: px, frame_start: fs};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (cells_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase();
        logic [5:0]  cw;
        logic [12:0] iw;
        logic [12:0] ih;
        int unsigned lw, lh, fw, fh, frame, beats, level, spread, px;
        bit          fs;
        case ($urandom_range(9))
            0:       cw = 6'($urandom_range(5, 63));
            default: cw = 6'($urandom_range(0, 4));
        endcase
        lw = (cw == 0) ? 1 : (cw > 32) ? 32 : cw;
        lh = 5 * lw / 2;
        case ($urandom_range(15))
            0:       iw = '0;
            1:       iw = '1;
            2:       iw = 13'd4096;
            default: iw = 13'($urandom_range(1, 4 * lw));
        endcase
        case ($urandom_range(15))
            0:       ih = '0;
            1:       ih = '1;
            default: ih = 13'($urandom_range(1, 3 * lh));
        endcase
        fw = (iw == 0) ? 1 : (iw > 4096) ? 4096 : iw;
        fh = (ih == 0) ? 1 : (ih > 4096) ? 4096 : ih;
        frame = fw * fh;
        beats = frame * $urandom_range(1, 3) + $urandom_range(0, fw);
        if (beats > MAX_PHASE) beats = MAX_PHASE;
        level  = $urandom_range(255);
        spread = $urandom_range(60);
        configure(cw, iw, ih);
        for (int unsigned i = 0; i < beats; i++) begin
            if (i == 0) begin
                fs = 1'b1;
            end else if (i % frame == 0) begin
                fs = 1'($urandom_range(1));
            end else begin
                fs = 1'b0;
            end
            if ($urandom_range(99) < 3) fs = 1'b1;
            if ($urandom_range(9) == 0) begin
                px = $urandom_range(255);
            end else begin
                px = level + $urandom_range(0, 2 * spread);
                px = (px < spread) ? 0 : px - spread;
                if (px > 255) px = 255;
            end
            send_pixel(8'(px), fs);
        end
        random_sent += beats;
        wait_drained();
    endtask

    initial begin
        int unsigned phase;
        phase = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // glyph thresholds and pixel extremes, zero cell width acting as one
        write_reg(SPARE_INDEX, '1);
        configure(6'd0, 13'd12, 13'd2);
        for (int i = 0; i < 24; i++) send_pixel(GLYPH_EDGES[i % 12], i == 0);
        wait_drained();

        // cell shrunk mid-frame: mean above full scale saturates
        configure(6'd3, 13'd3, 13'd7);
        for (int i = 0; i < 3; i++) send_pixel(8'hFF, i == 0);
        wait_drained();
        write_reg(bma_pkg::CFG_CELL_WIDTH, 13'd1);
        send_pixel(8'hFF, 1'b0);
        wait_drained();

        // oversized cell width clamps to the widest cell, frame widened on its last row
        configure(6'd63, 13'd1, 13'd80);
        for (int i = 0; i < 79; i++) send_pixel(8'hFF, i == 0);
        wait_drained();
        write_reg(bma_pkg::CFG_IMAGE_WIDTH, 13'd32);
        for (int i = 0; i < 32; i++) send_pixel(8'($urandom_range(255)), 1'b0);
        wait_drained();

        // cell wider than the frame: nothing fits
        configure(6'd32, 13'd20, 13'd3);
        for (int i = 0; i < 30; i++) send_pixel(8'($urandom_range(255)), i == 0);
        wait_drained();

        // single pixel frame
        configure(6'd1, 13'd1, 13'd1);
        for (int i = 0; i < 10; i++) send_pixel(8'($urandom_range(255)), i == 0);
        wait_drained();

        // results pile up behind a long receiver hold-off
        configure(6'd1, 13'd4, 13'd2);
        @(posedge aclk);
        holds_asked++;
        for (int i = 0; i < 80; i++) send_pixel(8'($urandom_range(255)), i == 0);
        wait_drained();

        while (random_sent < RANDOM_BEATS) begin
            calm = (phase < 3);
            random_phase();
            phase++;
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/bma_pkg.sv
hdl/bma_sum_ram.sv
hdl/bma_div.sv
hdl/block_mean_ascii_art_unit.sv
bench/cell_glyph_checker.sv
bench/tb.sv
